// ===== rtl/asl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_pkg
// Shared widths, types and the CORDIC arctangent table for the angle slew
// limiter.
// ----------------------------------------------------------------------------
package asl_pkg;

    // Field widths
    localparam int VEC_WIDTH    = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_ITERS = 16;
    localparam int STAMP_W      = 32;
    localparam int RATE_W       = 32;
    localparam int OUT_ANGLE_W  = 16;

    // CORDIC datapath: input plus headroom for negation and gain
    localparam int CW      = VEC_WIDTH + 3;
    localparam int ZW      = 32;
    localparam int ITER_W  = $clog2(CORDIC_ITERS);
    localparam logic [ZW-1:0] Z_HALF  = {1'b1, {(ZW-1){1'b0}}};
    localparam logic [ZW-1:0] Z_ROUND = ZW'(1) << (ZW - 1 - ANGLE_WIDTH);

    // Serial limit multiplier
    localparam int LIM_SHIFT = 16;
    localparam int CNT_W     = $clog2(STAMP_W);
    localparam int ACC_W     = (ANGLE_WIDTH + LIM_SHIFT + 1 > RATE_W) ?
                               ANGLE_WIDTH + LIM_SHIFT + 2 : RATE_W + 2;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    localparam logic [ACC_W-1:0] SAT_LIM =
        (ACC_W'(HALF_TURN) + ACC_W'(1)) << LIM_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT_GO,
        ST_TGT_RUN,
        ST_SRC_RUN,
        ST_APPLY
    } asl_state_t;

    typedef struct packed {
        logic                        start;
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
    } cordic_cmd_t;

    typedef struct packed {
        logic                   done;
        logic [ANGLE_WIDTH-1:0] angle;
    } cordic_stat_t;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] rate;
        logic [STAMP_W-1:0] dt;
    } mul_cmd_t;

    typedef struct packed {
        logic                   busy;
        logic [ANGLE_WIDTH-1:0] lim;
    } mul_stat_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/asl_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_intf
// Valid/ready channels of the angle slew limiter: frame in, result out and
// the rate register write.
// ----------------------------------------------------------------------------
interface asl_frame_if;
    logic                                valid;
    logic                                ready;
    logic signed [asl_pkg::VEC_WIDTH-1:0] tgt_x;
    logic signed [asl_pkg::VEC_WIDTH-1:0] tgt_y;
    logic signed [asl_pkg::VEC_WIDTH-1:0] src_x;
    logic signed [asl_pkg::VEC_WIDTH-1:0] src_y;
    logic [asl_pkg::STAMP_W-1:0]          stamp_us;

    modport source (output valid, tgt_x, tgt_y, src_x, src_y, stamp_us,
                    input ready);
    modport sink   (input valid, tgt_x, tgt_y, src_x, src_y, stamp_us,
                    output ready);
endinterface

interface asl_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [asl_pkg::OUT_ANGLE_W-1:0] angle;
    logic                                   was_limited;
    logic                                   was_held;

    modport source (output valid, angle, was_limited, was_held, input ready);
    modport sink   (input valid, angle, was_limited, was_held, output ready);
endinterface

interface asl_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [asl_pkg::RATE_W-1:0] max_rate;

    modport source (output valid, max_rate, input ready);
    modport sink   (input valid, max_rate, output ready);
endinterface

// ===== rtl/asl_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle; returns atan2 as
// a rounded binary angle.
// ----------------------------------------------------------------------------
module asl_cordic
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  asl_pkg::cordic_cmd_t  cmd,
    output asl_pkg::cordic_stat_t stat
);

    logic signed [asl_pkg::CW-1:0] x_reg, x_next;
    logic signed [asl_pkg::CW-1:0] y_reg, y_next;
    logic [asl_pkg::ZW-1:0]        z_reg, z_next;
    logic [asl_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic signed [asl_pkg::CW-1:0] xe, ye, xs, ys;
    logic                          y_pos;
    logic [asl_pkg::ZW-1:0]        tab, z_rnd;

    always_comb
    begin
        xe    = asl_pkg::CW'(cmd.x);
        ye    = asl_pkg::CW'(cmd.y);
        xs    = x_reg >>> iter_reg;
        ys    = y_reg >>> iter_reg;
        y_pos = !y_reg[asl_pkg::CW-1] && (y_reg != '0);
        tab   = asl_pkg::atan_entry(5'(iter_reg));

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            // left half plane: turn by a half turn first
            if (xe[asl_pkg::CW-1])
            begin
                x_next = -xe;
                y_next = -ye;
                z_next = asl_pkg::Z_HALF;
            end
            else
            begin
                x_next = xe;
                y_next = ye;
                z_next = '0;
            end
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_pos)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + tab;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - tab;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == asl_pkg::ITER_W'(asl_pkg::CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // round half up to the angle width
    assign z_rnd      = z_reg + asl_pkg::Z_ROUND;
    assign stat.angle = z_rnd[asl_pkg::ZW-1 -: asl_pkg::ANGLE_WIDTH];
    assign stat.done  = done_reg;

endmodule

// ===== rtl/asl_slew_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_slew_mul
// Bit-serial rate * dt multiplier, one dt bit per cycle MSB first, giving
// the step limit (product >> 16) saturated at a half turn.
// ----------------------------------------------------------------------------
module asl_slew_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  asl_pkg::mul_cmd_t  cmd,
    output asl_pkg::mul_stat_t stat
);

    logic [asl_pkg::RATE_W-1:0]  rate_reg, rate_next;
    logic [asl_pkg::STAMP_W-1:0] dt_reg, dt_next;
    logic [asl_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [asl_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        sat_reg, sat_next;
    logic                        busy_reg, busy_next;

    logic [asl_pkg::ACC_W-1:0]   acc_sum;

    always_comb
    begin
        acc_sum = {acc_reg[asl_pkg::ACC_W-2:0], 1'b0} +
                  (dt_reg[asl_pkg::STAMP_W-1] ? asl_pkg::ACC_W'(rate_reg) : '0);

        rate_next = rate_reg;
        dt_next   = dt_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        busy_next = busy_reg;

        if (cmd.start)
        begin
            rate_next = cmd.rate;
            dt_next   = cmd.dt;
            acc_next  = '0;
            cnt_next  = '0;
            sat_next  = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dt_next  = {dt_reg[asl_pkg::STAMP_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            // once past the limit the product only grows: freeze
            if (!sat_reg)
            begin
                if (acc_sum >= asl_pkg::SAT_LIM)
                    sat_next = 1'b1;
                else
                    acc_next = acc_sum;
            end
            if (cnt_reg == asl_pkg::CNT_W'(asl_pkg::STAMP_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sat_reg  <= sat_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
        dt_reg   <= dt_next;
        acc_reg  <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.lim  = sat_reg ? asl_pkg::HALF_TURN :
                       acc_reg[asl_pkg::LIM_SHIFT +: asl_pkg::ANGLE_WIDTH];

endmodule

// ===== rtl/angle_slew_limiter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_slew_limiter_unit
// Desired angle = atan2(target) - atan2(source), then slew limited against
// the stored angle by max_rate * elapsed time when max_rate is nonzero.
// ----------------------------------------------------------------------------
// A frame runs the shared CORDIC twice, target then source, then applies the
//   clamp once the limit multiplier is idle and the output register is free.
// No new frame is taken until the last one is applied; the serial limit
//   multiplier runs alongside the CORDIC.
// A finished result sits in the output register while the next frame is taken.
// Reset: stored angle, last stamp and max_rate clear to zero; no result pending.
// ----------------------------------------------------------------------------
module angle_slew_limiter_unit
(
    input  logic         clk,
    input  logic         rst_n,
    asl_cfg_if.sink      cfg,
    asl_frame_if.sink    frame,
    asl_result_if.source result
);

    // FSM
    asl_pkg::asl_state_t state_reg, state_next;

    // captured frame
    logic signed [asl_pkg::VEC_WIDTH-1:0] tx_reg, tx_next;
    logic signed [asl_pkg::VEC_WIDTH-1:0] ty_reg, ty_next;
    logic signed [asl_pkg::VEC_WIDTH-1:0] sx_reg, sx_next;
    logic signed [asl_pkg::VEC_WIDTH-1:0] sy_reg, sy_next;
    logic [asl_pkg::STAMP_W-1:0]          stamp_reg, stamp_next;
    logic                                 held_reg, held_next;

    // angles
    logic [asl_pkg::ANGLE_WIDTH-1:0] ang_t_reg, ang_t_next;
    logic [asl_pkg::ANGLE_WIDTH-1:0] desired_reg, desired_next;

    // architectural state
    logic [asl_pkg::ANGLE_WIDTH-1:0] cur_angle_reg, cur_angle_next;
    logic [asl_pkg::STAMP_W-1:0]     last_stamp_reg, last_stamp_next;
    logic [asl_pkg::RATE_W-1:0]      max_rate_reg;

    // output register
    logic                                  out_valid_reg, out_valid_next;
    logic signed [asl_pkg::OUT_ANGLE_W-1:0] out_angle_reg, out_angle_next;
    logic                                  out_lim_reg, out_lim_next;
    logic                                  out_held_reg, out_held_next;

    asl_pkg::cordic_cmd_t  cor_cmd;
    asl_pkg::cordic_stat_t cor_stat;
    asl_pkg::mul_cmd_t     mul_cmd;
    asl_pkg::mul_stat_t    mul_stat;

    // clamp path
    logic                                  frame_acc;
    logic [asl_pkg::ANGLE_WIDTH-1:0]       delta, step, new_angle;
    logic signed [asl_pkg::ANGLE_WIDTH:0]  delta_x, lim_x, lim_sum;
    logic                                  over_pos, over_neg, limiting;
    logic                                  apply_go;

    asl_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cor_cmd),
        .stat  (cor_stat)
    );

    asl_slew_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .stat  (mul_stat)
    );

    // user must keep the register written only while idle; not enforced here, so it is always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_rate_reg <= '0;
        else if (cfg.valid)
            max_rate_reg <= cfg.max_rate;
    end

    assign frame.ready = (state_reg == asl_pkg::ST_IDLE);
    assign frame_acc   = frame.valid && frame.ready;

    // limit multiply starts at accept; dt wraps mod 2^32
    assign mul_cmd.start = frame_acc;
    assign mul_cmd.rate  = max_rate_reg;
    assign mul_cmd.dt    = frame.stamp_us - last_stamp_reg;

    // step wrapped to a half turn, clamped to [-lim, lim]
    always_comb
    begin
        delta     = desired_reg - cur_angle_reg;
        delta_x   = {delta[asl_pkg::ANGLE_WIDTH-1], delta};
        lim_x     = {1'b0, mul_stat.lim};
        lim_sum   = delta_x + lim_x;
        over_pos  = delta_x > lim_x;
        over_neg  = lim_sum[asl_pkg::ANGLE_WIDTH];
        limiting  = (max_rate_reg != '0);
        if (over_pos)
            step = mul_stat.lim;
        else if (over_neg)
            step = '0 - mul_stat.lim;
        else
            step = delta;
        new_angle = limiting ? (cur_angle_reg + step) : desired_reg;
    end

    assign apply_go = !mul_stat.busy && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        stamp_next      = stamp_reg;
        held_next       = held_reg;
        ang_t_next      = ang_t_reg;
        desired_next    = desired_reg;
        cur_angle_next  = cur_angle_reg;
        last_stamp_next = last_stamp_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_angle_next  = out_angle_reg;
        out_lim_next    = out_lim_reg;
        out_held_next   = out_held_reg;

        cor_cmd.start = 1'b0;
        cor_cmd.x     = tx_reg;
        cor_cmd.y     = ty_reg;

        case (state_reg)
            asl_pkg::ST_IDLE:
            begin
                if (frame_acc)
                begin
                    tx_next    = frame.tgt_x;
                    ty_next    = frame.tgt_y;
                    sx_next    = frame.src_x;
                    sy_next    = frame.src_y;
                    stamp_next = frame.stamp_us;
                    held_next  = ((frame.tgt_x == '0) && (frame.tgt_y == '0)) ||
                                 ((frame.src_x == '0) && (frame.src_y == '0));
                    state_next = asl_pkg::ST_TGT_GO;
                end
            end

            asl_pkg::ST_TGT_GO:
            begin
                cor_cmd.start = 1'b1;
                state_next    = asl_pkg::ST_TGT_RUN;
            end

            asl_pkg::ST_TGT_RUN:
            begin
                // target done: start source in the same cycle
                if (cor_stat.done)
                begin
                    ang_t_next    = cor_stat.angle;
                    cor_cmd.start = 1'b1;
                    cor_cmd.x     = sx_reg;
                    cor_cmd.y     = sy_reg;
                    state_next    = asl_pkg::ST_SRC_RUN;
                end
            end

            asl_pkg::ST_SRC_RUN:
            begin
                if (cor_stat.done)
                begin
                    desired_next = held_reg ? cur_angle_reg : (ang_t_reg - cor_stat.angle);
                    state_next   = asl_pkg::ST_APPLY;
                end
            end

            asl_pkg::ST_APPLY:
            begin
                if (apply_go)
                begin
                    cur_angle_next  = new_angle;
                    last_stamp_next = stamp_reg;
                    out_valid_next  = 1'b1;
                    out_angle_next  = asl_pkg::OUT_ANGLE_W'(signed'(new_angle));
                    out_lim_next    = limiting && (over_pos || over_neg);
                    out_held_next   = held_reg;
                    state_next      = asl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = asl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= asl_pkg::ST_IDLE;
            cur_angle_reg  <= '0;
            last_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_angle_reg  <= cur_angle_next;
            last_stamp_reg <= last_stamp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        stamp_reg     <= stamp_next;
        held_reg      <= held_next;
        ang_t_reg     <= ang_t_next;
        desired_reg   <= desired_next;
        out_angle_reg <= out_angle_next;
        out_lim_reg   <= out_lim_next;
        out_held_reg  <= out_held_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.angle       = out_angle_reg;
    assign result.was_limited = out_lim_reg;
    assign result.was_held    = out_held_reg;

endmodule

// ===== rtl/asl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asl_checker
// Port-level checks on the angle slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
module asl_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [asl_pkg::OUT_ANGLE_W-1:0] out_angle,
    input logic                            out_limited,
    input logic                            out_held
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(out_angle) && $stable(out_limited) && $stable(out_held)))
        else $error("result payload changed while stalled");

    // one frame at a time
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("frame taken while busy");

    // held step is zero, so it can never be clamped
    a_held_not_limited: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_held && out_limited))
        else $error("held result flagged as limited");

endmodule

bind angle_slew_limiter_unit asl_checker u_asl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (frame.valid),
    .in_ready    (frame.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_angle   (result.angle),
    .out_limited (result.was_limited),
    .out_held    (result.was_held)
);

// ===== dv/angle_slew_limiter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_slew_limiter_unit_tb
// Self-checking bench for the angle slew limiter. A short directed list
// (reset state, zero vectors, half-turn steps, clamp edges, timestamp wrap,
// rate extremes) runs first. About 700 random frames follow, under several
// rate settings and three handshake idling mixes. Every result is checked
// against its hand-typed value or a bit-exact CORDIC/slew predictor in the bench.
// ----------------------------------------------------------------------------
module angle_slew_limiter_unit_tb;

    localparam int ANGLE_W     = asl_pkg::ANGLE_WIDTH;
    localparam int DIR_ROWS    = 23;
    localparam int CHUNK_ITEMS = 57;          // frames per rate setting
    localparam int CYCLE_LIMIT = 400_000;     // watchdog cycle limit for the whole run
    localparam int HOLD_AT     = 300;         // result count that starts the long stall
    localparam int HOLD_CYCLES = 500;         // long receiver hold-off
    localparam int TAIL_CYCLES = 60;          // idle tail after every result is back
    localparam longint unsigned HALF = 64'd1 << (ANGLE_W - 1);

    // atan(2^-i), units of 2^-32 turn
    localparam bit [31:0] ATAN_TURN [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [asl_pkg::VEC_WIDTH-1:0] tx;
        logic signed [asl_pkg::VEC_WIDTH-1:0] ty;
        logic signed [asl_pkg::VEC_WIDTH-1:0] sx;
        logic signed [asl_pkg::VEC_WIDTH-1:0] sy;
        logic [asl_pkg::STAMP_W-1:0]          stamp;
    } frame_t;

    typedef struct packed {
        logic signed [asl_pkg::OUT_ANGLE_W-1:0] angle;
        logic                                   limited;
        logic                                   held;
    } angle_res_t;

    // One row of the directed list: either a rate write or a frame, and for
    // frames whose outcome is obvious, the result typed in by hand.
    typedef struct packed {
        logic                       is_rate;
        logic [asl_pkg::RATE_W-1:0] rate;
        frame_t                     item;
        logic                       known;
        angle_res_t                 known_res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    asl_cfg_if    cfg_ch ();
    asl_frame_if  frm_ch ();
    asl_result_if res_ch ();

    angle_slew_limiter_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .frame  (frm_ch),
        .result (res_ch)
    );

    // Predictor state: mirror of the stored angle, last stamp and rate reg
    logic [ANGLE_W-1:0]          pred_angle;
    logic [asl_pkg::STAMP_W-1:0] pred_stamp;
    logic [asl_pkg::RATE_W-1:0]  rate_setting;

    angle_res_t expected_angles [$];
    dir_row_t   dir_tab [DIR_ROWS];

    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count;
    int mismatches;
    int frames_sent;
    int results_seen;
    int rate_writes;
    int clamped_seen;
    int held_seen;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Vectoring CORDIC bearing of (x, y); 64-bit datapath, floor shifts,
    // left half-plane folded by a half turn, rounded half up to ANGLE_W.
    function automatic logic [ANGLE_W-1:0] cordic_bearing(longint x, longint y);
        logic [31:0] z;
        longint      xs;
        longint      ys;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < asl_pkg::CORDIC_ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i];
            end
        end
        z = z + (32'd1 << (31 - ANGLE_W));
        return z[31 -: ANGLE_W];
    endfunction

    // Applies one frame to the predictor state and returns its result.
    function automatic angle_res_t slew_angle(frame_t f);
        angle_res_t                  r;
        logic [ANGLE_W-1:0]          desired;
        logic signed [ANGLE_W-1:0]   turn;
        longint                      d;
        longint unsigned             lim;
        logic [asl_pkg::STAMP_W-1:0] dt;
        r.limited = 1'b0;
        r.held    = 1'b0;
        if ((f.tx != 0 || f.ty != 0) && (f.sx != 0 || f.sy != 0))
        begin
            desired = cordic_bearing(f.tx, f.ty) - cordic_bearing(f.sx, f.sy);
        end
        else
        begin
            // zero vector: hold the stored angle
            desired = pred_angle;
            r.held  = 1'b1;
        end
        if (rate_setting == '0)
        begin
            pred_angle = desired;
        end
        else
        begin
            // shortest way round, then clamp to rate * dt (capped at half turn)
            turn = desired - pred_angle;
            d    = turn;
            dt   = f.stamp - pred_stamp;
            lim  = ({32'd0, rate_setting} * {32'd0, dt}) >> asl_pkg::LIM_SHIFT;
            if (lim > HALF)
            begin
                lim = HALF;
            end
            if (d > longint'(lim))
            begin
                d         = longint'(lim);
                r.limited = 1'b1;
            end
            else if (d < -longint'(lim))
            begin
                d         = -longint'(lim);
                r.limited = 1'b1;
            end
            pred_angle = pred_angle + d[ANGLE_W-1:0];
        end
        pred_stamp = f.stamp;
        r.angle    = pred_angle;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed list builders
    // ------------------------------------------------------------------
    function automatic dir_row_t dir_frame(int tx, int ty, int sx, int sy,
                                           logic [31:0] st);
        dir_row_t r;
        r = '0;
        r.item.tx    = tx[15:0];
        r.item.ty    = ty[15:0];
        r.item.sx    = sx[15:0];
        r.item.sy    = sy[15:0];
        r.item.stamp = st;
        return r;
    endfunction

    function automatic dir_row_t dir_known(int tx, int ty, int sx, int sy,
                                           logic [31:0] st, int ang,
                                           bit lim, bit hld);
        dir_row_t r;
        r = dir_frame(tx, ty, sx, sy, st);
        r.known             = 1'b1;
        r.known_res.angle   = ang[15:0];
        r.known_res.limited = lim;
        r.known_res.held    = hld;
        return r;
    endfunction

    function automatic dir_row_t dir_rate(logic [31:0] v);
        dir_row_t r;
        r = '0;
        r.is_rate = 1'b1;
        r.rate    = v;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic logic signed [asl_pkg::VEC_WIDTH-1:0] rand_comp();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            1, 2:    return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Stamps mostly move forward by a few ms; now and then jump or step back.
    function automatic frame_t rand_frame();
        frame_t f;
        f.tx = rand_comp();
        f.ty = rand_comp();
        f.sx = rand_comp();
        f.sy = rand_comp();
        if ($urandom_range(99) < 8)
        begin
            f.tx = '0;
            f.ty = '0;
        end
        if ($urandom_range(99) < 8)
        begin
            f.sx = '0;
            f.sy = '0;
        end
        case ($urandom_range(19))
            0:       f.stamp = $urandom;
            1:       f.stamp = pred_stamp - $urandom_range(1, 500);
            default: f.stamp = pred_stamp + $urandom_range(0, 3000);
        endcase
        return f;
    endfunction

    function automatic logic [asl_pkg::RATE_W-1:0] pick_rate();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'd1;
            2:       return $urandom_range(1, 1 << 20);
            3:       return $urandom_range(1, 64) << 16;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers (inputs change on the falling edge, handshakes sampled on
    // the rising edge)
    // ------------------------------------------------------------------

    // Sender pause: nothing new goes in until every result is back.
    task automatic drain_results();
        while (expected_angles.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Rate writes only happen with the block empty.
    task automatic write_rate(logic [asl_pkg::RATE_W-1:0] v);
        drain_results();
        cfg_ch.max_rate = v;
        cfg_ch.valid    = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        rate_setting = v;
        rate_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Offers one frame; on accept, advances the predictor and queues the
    // expected result (the hand-typed one where given).
    task automatic send_frame(frame_t f, bit known, angle_res_t known_res);
        angle_res_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            frm_ch.valid = 1'b0;
            @(negedge clk);
        end
        frm_ch.tgt_x    = f.tx;
        frm_ch.tgt_y    = f.ty;
        frm_ch.src_x    = f.sx;
        frm_ch.src_y    = f.sy;
        frm_ch.stamp_us = f.stamp;
        frm_ch.valid    = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!frm_ch.ready);
        r = slew_angle(f);
        expected_angles.push_back(known ? known_res : r);
        frames_sent++;
        @(negedge clk);
        // item taken: withdraw it so it is not offered twice
        frm_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off once enough
    // results have come so that the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else
            begin
                res_ch.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        angle_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] result with nothing pending: angle=%0d lim=%0b held=%0b",
                             $realtime, res_ch.angle, res_ch.was_limited, res_ch.was_held);
                end
            end
            else
            begin
                want = expected_angles.pop_front();
                if (want.limited)
                begin
                    clamped_seen++;
                end
                if (want.held)
                begin
                    held_seen++;
                end
                if (res_ch.angle !== want.angle || res_ch.was_limited !== want.limited ||
                    res_ch.was_held !== want.held)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] result %0d: exp angle=%0d lim=%0b held=%0b,",
                                 $realtime, results_seen, want.angle, want.limited,
                                 want.held);
                        $display("    got angle=%0d lim=%0b held=%0b",
                                 res_ch.angle, res_ch.was_limited, res_ch.was_held);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("angle_slew_limiter_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        angle_res_t no_res;
        no_res = '0;

        // known values on every input from time zero
        rst_n           = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.max_rate = '0;
        frm_ch.valid    = 1'b0;
        frm_ch.tgt_x    = '0;
        frm_ch.tgt_y    = '0;
        frm_ch.src_x    = '0;
        frm_ch.src_y    = '0;
        frm_ch.stamp_us = '0;
        pred_angle      = '0;
        pred_stamp      = '0;
        rate_setting    = '0;
        cycle_count     = 0;
        mismatches      = 0;
        frames_sent     = 0;
        results_seen    = 0;
        rate_writes     = 0;
        clamped_seen    = 0;
        held_seen       = 0;
        tx_idle_pct     = 25;
        rx_idle_pct     = 68;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed list. (1,0) vs (1,0) gives exactly zero; (-1,0) vs (1,0)
        // gives exactly a half turn, since the fold adds 2^31 to an otherwise
        // identical CORDIC run. Clamp rows are worked from those two.
        dir_tab = '{
            // rate off after reset
            dir_known(0, 0, 0, 0, 0, 0, 0, 1),              // both vectors zero
            dir_known(1, 0, 1, 0, 10, 0, 0, 0),
            dir_known(-1, 0, 1, 0, 20, -32768, 0, 0),       // half turn
            dir_known(0, 0, 5, 7, 30, -32768, 0, 1),        // target zero
            dir_known(3, 4, 0, 0, 40, -32768, 0, 1),        // source zero
            dir_frame(32767, 32767, -32768, -32768, 50),
            dir_frame(-32768, 32767, 32767, -32768, 60),
            dir_frame(0, -32768, -32768, 0, 70),
            dir_known(-1, 0, 1, 0, 80, -32768, 0, 0),
            // 1 LSB/us: dt=100 clamps a half-turn step to -100
            dir_rate(32'h0001_0000),
            dir_known(1, 0, 1, 0, 180, 32668, 1, 0),
            dir_known(0, 0, 0, 0, 200, 32668, 0, 1),        // held, no step
            dir_known(1, 0, 1, 0, 200, 32668, 1, 0),        // dt=0, no move
            // max rate: backwards stamp -> huge dt, limit capped at half turn
            dir_rate(32'hFFFF_FFFF),
            dir_known(1, 0, 1, 0, 199, 0, 0, 0),
            dir_known(-1, 0, 1, 0, 199, 0, 1, 0),           // dt=0
            dir_known(-1, 0, 1, 0, 200, -32768, 0, 0),      // limit exactly half
            // minimum rate, stamp at top then wrapping
            dir_rate(32'd1),
            dir_known(1, 0, 1, 0, 32'hFFFF_FFFF, 0, 0, 0),
            dir_frame(12000, -9000, -7000, 15000, 5),
            dir_rate(32'h0080_0000),
            dir_frame(-20000, -3, 17, -32768, 105),
            dir_frame(32767, -32768, -32768, 32767, 32'h8000_0000)
        };

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_rate)
            begin
                write_rate(dir_tab[i].rate);
            end
            else
            begin
                send_frame(dir_tab[i].item, dir_tab[i].known, dir_tab[i].known_res);
            end
        end

        // Random part: three idling mixes, four rate settings each; the last
        // setting of every mix turns limiting off.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 68;
                end
                1:
                begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 25;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                write_rate((chunk == 3) ? 32'd0 : pick_rate());
                repeat (CHUNK_ITEMS)
                begin
                    send_frame(rand_frame(), 1'b0, no_res);
                end
            end
        end
        frm_ch.valid = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d frames (%0d results, %0d clamped, %0d held) over %0d rate writes,",
                 frames_sent, results_seen, clamped_seen, held_seen, rate_writes);
        $display("three stall mixes and one %0d-cycle output hold-off; %0d mismatches.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0 && expected_angles.size() == 0)
        begin
            $display("angle_slew_limiter_unit verification clean");
        end
        else
        begin
            $display("angle_slew_limiter_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/asl_pkg.sv
rtl/asl_intf.sv
rtl/asl_cordic.sv
rtl/asl_slew_mul.sv
rtl/angle_slew_limiter_unit.sv
rtl/asl_checker.sv
dv/angle_slew_limiter_unit_tb.sv
